@@ rtl/core/tmst_pkg.sv @@
// Package for the touch message slot tracker.
// Holds the slot record type, widths, register indexes and helpers.
// No dependencies.
`default_nettype none

package tmst_pkg;

    // Number of touch slots held in the cell chain.
    localparam int NUM_SLOTS = 16;

    // Width of a touch id inside the chain, and of slot counters.
    localparam int TID_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);

    // Fixed field widths.
    localparam int ID_W     = 8;
    localparam int WORD_W   = 16;
    localparam int CSUM_W   = 24;
    localparam int OUT_TID_W = 4;
    localparam int CFG_IDX_W = 2;

    // Report ids that carry no message.
    localparam logic [ID_W-1:0] RID_NONE_LO = 8'h00;
    localparam logic [ID_W-1:0] RID_NONE_HI = 8'hFF;

    // Offset of the first touch id above the multitouch base id.
    localparam logic [ID_W-1:0] TOUCH_ID_OFFSET = 8'd2;

    // Position of the detect flag in the touch status byte.
    localparam int DETECT_BIT = 7;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_ID = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MT_FIRST   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MT_LAST    = 2'd2;

    // Record kinds on the output.
    localparam logic KIND_TOUCH  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // One slot as it travels along the chain.
    typedef struct packed {
        logic [TID_W-1:0]  tid;
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] y;
        logic              active;
    } t_slot;

    // Touch id as it leaves the block: zero extended or cut to four bits.
    function automatic logic [OUT_TID_W-1:0] out_tid(input logic [TID_W-1:0] tid);
        logic [31:0] wide;
        wide = 32'(tid);
        return wide[OUT_TID_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/tmst_slot_cell.sv @@
// One cell of the slot chain: holds a single slot record.
// Depends on tmst_pkg for the slot record type.
`default_nettype none

module tmst_slot_cell (
    input  wire              i_clk,
    input  wire              i_shift,
    input  wire              i_load,
    input  tmst_pkg::t_slot  i_next,
    input  tmst_pkg::t_slot  i_load_data,
    output tmst_pkg::t_slot  o_slot
);

    tmst_pkg::t_slot r_slot;
    tmst_pkg::t_slot n_slot;

    // A direct load wins over taking the neighbor's record.
    always_comb begin
        n_slot = r_slot;
        if (i_load) begin
            n_slot = i_load_data;
        end else if (i_shift) begin
            n_slot = i_next;
        end
    end

    // Slot contents are payload and need no reset.
    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    assign o_slot = r_slot;

endmodule

`default_nettype wire

@@ rtl/core/touch_message_slot_tracker.sv @@
// Timing: a status record is shown in the cycle after its request; a touch request walks the
// slot chain, which shifts once per held slot past its head cell, before it takes another.
// A batch flush walks the chain for active, then released slots, and waits on output stalls.
// Throughput: one ignored or status request per cycle while the output is not stalled; no
// new request is taken during a chain walk or a flush.
// Reset (synchronous, active low) clears state, config registers, counts, saved status and output valid.
`default_nettype none

module touch_message_slot_tracker (
    input  wire        i_clk,
    input  wire        i_rst_n,
    // Message requests.
    input  wire        i_valid,
    output logic       o_ready,
    input  wire [7:0]  i_msg_id,
    input  wire [7:0]  i_status_byte,
    input  wire [15:0] i_word_a,
    input  wire [15:0] i_word_b,
    input  wire        i_end_of_batch,
    // Result records.
    output logic       o_valid,
    input  wire        i_ready,
    output logic       o_record_kind,
    output logic [3:0] o_finger_id,
    output logic [15:0] o_pos_x,
    output logic [15:0] o_pos_y,
    output logic       o_pressed,
    output logic       o_last_in_run,
    output logic [7:0] o_command_status,
    output logic [23:0] o_config_checksum,
    // Configuration writes.
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire [1:0]  i_cfg_index,
    input  wire [7:0]  i_cfg_data
);

    localparam int N     = tmst_pkg::NUM_SLOTS;
    localparam int CNT_W = tmst_pkg::CNT_W;
    localparam int TID_W = tmst_pkg::TID_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH_ACT,
        ST_FLUSH_REL
    } t_state;

    // Control registers.
    t_state            r_state, n_state;
    logic [7:0]        r_cmd_id, n_cmd_id;
    logic [7:0]        r_mt_first, n_mt_first;
    logic [7:0]        r_mt_last, n_mt_last;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_act, n_act;
    logic [CNT_W-1:0]  r_k, n_k;
    logic [CNT_W-1:0]  r_t, n_t;
    logic [CNT_W-1:0]  r_done, n_done;
    logic              r_found, n_found;
    logic              r_eob, n_eob;
    logic              r_out_valid, n_out_valid;
    logic [7:0]        r_saved_status, n_saved_status;
    logic [23:0]       r_saved_csum, n_saved_csum;

    // Payload registers of the current touch request.
    logic [TID_W-1:0]  r_tid, n_tid;
    logic              r_detect, n_detect;
    logic [15:0]       r_wa, n_wa;
    logic [15:0]       r_wb, n_wb;

    // Output record registers.
    logic              r_o_kind, n_o_kind;
    logic [3:0]        r_o_tid, n_o_tid;
    logic [15:0]       r_o_x, n_o_x;
    logic [15:0]       r_o_y, n_o_y;
    logic              r_o_pressed, n_o_pressed;
    logic              r_o_last, n_o_last;
    logic [7:0]        r_o_status, n_o_status;
    logic [23:0]       r_o_csum, n_o_csum;

    // Chain control.
    tmst_pkg::t_slot   w_slot [N];
    tmst_pkg::t_slot   w_head;
    tmst_pkg::t_slot   w_push_data;
    logic              w_shift;
    logic              w_push;
    logic [CNT_W-1:0]  w_push_idx;

    // Request classification.
    logic              w_out_free;
    logic              w_accept;
    logic              w_msg;
    logic              w_is_cmd;
    logic              w_is_touch;
    logic [7:0]        w_start;
    logic [7:0]        w_tid8;
    logic              w_match;

    assign w_head = w_slot[0];

    // Row of slot cells; each cell takes its right neighbor's record on a shift.
    for (genvar i = 0; i < N; i++) begin : g_cell
        tmst_pkg::t_slot w_next;
        logic            w_load;
        if (i == N - 1) begin : g_tail
            assign w_next = w_slot[i];
        end else begin : g_mid
            assign w_next = w_slot[i+1];
        end
        assign w_load = w_push && (w_push_idx == CNT_W'(i));
        tmst_slot_cell u_cell (
            .i_clk       (i_clk),
            .i_shift     (w_shift),
            .i_load      (w_load),
            .i_next      (w_next),
            .i_load_data (w_push_data),
            .o_slot      (w_slot[i])
        );
    end

    // Message decode, valid only in the idle state.
    always_comb begin
        w_start    = r_mt_first + tmst_pkg::TOUCH_ID_OFFSET;
        w_tid8     = i_msg_id - w_start;
        w_msg      = (i_msg_id != tmst_pkg::RID_NONE_LO) &&
                     (i_msg_id != tmst_pkg::RID_NONE_HI);
        w_is_cmd   = w_msg && (i_msg_id == r_cmd_id);
        w_is_touch = w_msg && !w_is_cmd && (i_msg_id >= w_start) &&
                     (i_msg_id <= r_mt_last) && ({1'b0, w_tid8} < 9'(N));
    end

    assign w_out_free = !r_out_valid || i_ready;
    assign o_ready    = (r_state == ST_IDLE) && w_out_free;
    assign w_accept   = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;
    assign w_match    = !r_found && (w_head.tid == r_tid);

    // Next-state logic for the sequencer, chain and output record.
    always_comb begin
        n_state        = r_state;
        n_cmd_id       = r_cmd_id;
        n_mt_first     = r_mt_first;
        n_mt_last      = r_mt_last;
        n_count        = r_count;
        n_act          = r_act;
        n_k            = r_k;
        n_t            = r_t;
        n_done         = r_done;
        n_found        = r_found;
        n_eob          = r_eob;
        n_saved_status = r_saved_status;
        n_saved_csum   = r_saved_csum;
        n_tid          = r_tid;
        n_detect       = r_detect;
        n_wa           = r_wa;
        n_wb           = r_wb;
        n_o_kind       = r_o_kind;
        n_o_tid        = r_o_tid;
        n_o_x          = r_o_x;
        n_o_y          = r_o_y;
        n_o_pressed    = r_o_pressed;
        n_o_last       = r_o_last;
        n_o_status     = r_o_status;
        n_o_csum       = r_o_csum;
        n_out_valid    = r_out_valid && !i_ready;
        w_shift        = 1'b0;
        w_push         = 1'b0;
        w_push_idx     = r_count - 1'b1;
        w_push_data    = w_head;

        // Register writes; an index beyond the list is ignored.
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tmst_pkg::CFG_COMMAND_ID: n_cmd_id   = i_cfg_data;
                tmst_pkg::CFG_MT_FIRST:   n_mt_first = i_cfg_data;
                tmst_pkg::CFG_MT_LAST:    n_mt_last  = i_cfg_data;
                default: ;
            endcase
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_eob    = i_end_of_batch;
                    n_tid    = w_tid8[TID_W-1:0];
                    n_detect = i_status_byte[tmst_pkg::DETECT_BIT];
                    n_wa     = i_word_a;
                    n_wb     = i_word_b;
                    n_k      = '0;
                    n_done   = '0;
                    n_found  = 1'b0;
                    if (w_is_cmd) begin
                        n_saved_status = i_status_byte;
                        n_saved_csum   = {i_word_b[7:0], i_word_a};
                        n_out_valid    = 1'b1;
                        n_o_kind       = tmst_pkg::KIND_STATUS;
                        n_o_tid        = '0;
                        n_o_x          = '0;
                        n_o_y          = '0;
                        n_o_pressed    = 1'b0;
                        n_o_last       = 1'b1;
                        n_o_status     = i_status_byte;
                        n_o_csum       = {i_word_b[7:0], i_word_a};
                    end
                    if (w_is_touch) begin
                        n_state = ST_SCAN;
                    end else if (i_end_of_batch) begin
                        n_state = ST_FLUSH_ACT;
                    end
                end
            end

            ST_SCAN: begin
                if (r_k != r_count) begin
                    // Walk every held slot past the head and back to the tail.
                    w_shift    = 1'b1;
                    w_push     = 1'b1;
                    w_push_idx = r_count - 1'b1;
                    n_k        = r_k + 1'b1;
                    if (w_match) begin
                        n_found = 1'b1;
                        if (r_detect) begin
                            w_push_data = '{tid: r_tid, x: r_wa, y: r_wb, active: 1'b1};
                            if (!w_head.active) begin
                                n_act = r_act + 1'b1;
                            end
                        end else begin
                            w_push_data.active = 1'b0;
                            if (w_head.active) begin
                                n_act = r_act - 1'b1;
                            end
                        end
                    end
                end else begin
                    // A new finger takes the next free slot, if there is one.
                    if (!r_found && r_detect && (r_count != CNT_W'(N))) begin
                        w_push      = 1'b1;
                        w_push_idx  = r_count;
                        w_push_data = '{tid: r_tid, x: r_wa, y: r_wb, active: 1'b1};
                        n_count     = r_count + 1'b1;
                        n_act       = r_act + 1'b1;
                    end
                    n_k     = '0;
                    n_done  = '0;
                    n_state = r_eob ? ST_FLUSH_ACT : ST_IDLE;
                end
            end

            ST_FLUSH_ACT: begin
                if (r_k != r_count) begin
                    // Report active slots; the chain order is kept intact.
                    if (!w_head.active || w_out_free) begin
                        w_shift    = 1'b1;
                        w_push     = 1'b1;
                        w_push_idx = r_count - 1'b1;
                        n_k        = r_k + 1'b1;
                        if (w_head.active) begin
                            n_done      = r_done + 1'b1;
                            n_out_valid = 1'b1;
                            n_o_kind    = tmst_pkg::KIND_TOUCH;
                            n_o_tid     = tmst_pkg::out_tid(w_head.tid);
                            n_o_x       = w_head.x;
                            n_o_y       = w_head.y;
                            n_o_pressed = 1'b1;
                            n_o_last    = (CNT_W'(r_done + 1'b1) == r_act) &&
                                          (r_count == r_act);
                            n_o_status  = '0;
                            n_o_csum    = '0;
                        end
                    end
                end else begin
                    n_k     = '0;
                    n_done  = '0;
                    n_t     = r_count;
                    n_state = ST_FLUSH_REL;
                end
            end

            ST_FLUSH_REL: begin
                if (r_k != r_count) begin
                    // Report released slots and drop them; active ones close up in order.
                    if (w_head.active || w_out_free) begin
                        w_shift = 1'b1;
                        n_k     = r_k + 1'b1;
                        if (w_head.active) begin
                            w_push     = 1'b1;
                            w_push_idx = r_t - 1'b1;
                        end else begin
                            n_t         = r_t - 1'b1;
                            n_done      = r_done + 1'b1;
                            n_out_valid = 1'b1;
                            n_o_kind    = tmst_pkg::KIND_TOUCH;
                            n_o_tid     = tmst_pkg::out_tid(w_head.tid);
                            n_o_x       = w_head.x;
                            n_o_y       = w_head.y;
                            n_o_pressed = 1'b0;
                            n_o_last    = (CNT_W'(r_done + 1'b1) ==
                                           CNT_W'(r_count - r_act));
                            n_o_status  = '0;
                            n_o_csum    = '0;
                        end
                    end
                end else begin
                    n_count = r_t;
                    n_state = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    // State, control and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_cmd_id       <= '0;
            r_mt_first     <= '0;
            r_mt_last      <= '0;
            r_count        <= '0;
            r_act          <= '0;
            r_k            <= '0;
            r_t            <= '0;
            r_done         <= '0;
            r_found        <= 1'b0;
            r_eob          <= 1'b0;
            r_out_valid    <= 1'b0;
            r_saved_status <= '0;
            r_saved_csum   <= '0;
        end else begin
            r_state        <= n_state;
            r_cmd_id       <= n_cmd_id;
            r_mt_first     <= n_mt_first;
            r_mt_last      <= n_mt_last;
            r_count        <= n_count;
            r_act          <= n_act;
            r_k            <= n_k;
            r_t            <= n_t;
            r_done         <= n_done;
            r_found        <= n_found;
            r_eob          <= n_eob;
            r_out_valid    <= n_out_valid;
            r_saved_status <= n_saved_status;
            r_saved_csum   <= n_saved_csum;
        end
        r_tid       <= n_tid;
        r_detect    <= n_detect;
        r_wa        <= n_wa;
        r_wb        <= n_wb;
        r_o_kind    <= n_o_kind;
        r_o_tid     <= n_o_tid;
        r_o_x       <= n_o_x;
        r_o_y       <= n_o_y;
        r_o_pressed <= n_o_pressed;
        r_o_last    <= n_o_last;
        r_o_status  <= n_o_status;
        r_o_csum    <= n_o_csum;
    end

    assign o_valid           = r_out_valid;
    assign o_record_kind     = r_o_kind;
    assign o_finger_id       = r_o_tid;
    assign o_pos_x           = r_o_x;
    assign o_pos_y           = r_o_y;
    assign o_pressed         = r_o_pressed;
    assign o_last_in_run     = r_o_last;
    assign o_command_status  = r_o_status;
    assign o_config_checksum = r_o_csum;

endmodule

`default_nettype wire
